>>> src/psup_pkg.sv
package psup_pkg;

  localparam int NODE_COUNT = 256;
  localparam int NODE_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [7:0]  RETRY_RESET   = 8'd3;
  localparam logic [7:0]  MISS_MAX      = 8'hff;
  localparam logic [15:0] WAIT_MAX      = 16'hffff;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_TICK  = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_BUSY      = 3'd1,
    ST_MATCHED   = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_IDLE_TICK = 3'd4,
    ST_RETRY     = 3'd5,
    ST_GIVE_UP   = 3'd6
  } status_t;

  typedef enum logic {
    CFG_TIMEOUT_TICKS = 1'b0,
    CFG_RETRY_LIMIT   = 1'b1
  } cfg_index_t;

endpackage

>>> src/psup_if.sv
interface psup_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  dest_node;
  logic [7:0]  request_code;
  logic [28:0] frame_id;

  modport source (output valid, command, dest_node, request_code, frame_id, input ready);
  modport sink (input valid, command, dest_node, request_code, frame_id, output ready);
endinterface

interface psup_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] resend_dest;
  logic [7:0] resend_code;
  logic [7:0] miss_count_out;

  modport source (output valid, status, resend_dest, resend_code, miss_count_out, input ready);
  modport sink (input valid, status, resend_dest, resend_code, miss_count_out, output ready);
endinterface

interface psup_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/poll_response_supervisor_top.sv
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   command, dest_node, request_code, frame_id
// rsp      out  valid/ready   status, resend_dest, resend_code, miss_count_out
// cfg      in   valid/ready   index (0 timeout_ticks, 1 retry_limit), data
//
// One transaction per cycle sustained unless rsp stalls; a request is
// registered in stage one, then in the rsp output register. Stage one updates
// the request registers and reads the miss-count RAM; stage two resolves retry
// or give-up and writes the count back, with forwarding of the last write.
// Reset is synchronous; a valid bit per node makes every miss count read as
// 255 after reset. A stall on rsp backs up into req via the output register.
module poll_response_supervisor_top (
  input  logic      clk,
  input  logic      rst,
  psup_req_if.sink  req,
  psup_rsp_if.source rsp,
  psup_cfg_if.sink  cfg
);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_TIMEOUT
  } op_t;

  localparam int AW = psup_pkg::NODE_AW;

  logic [15:0] timeout_ticks;
  logic [7:0]  retry_limit;

  logic        pending, pending_next;
  logic [7:0]  last_dest, last_dest_next;
  logic [7:0]  last_code, last_code_next;
  logic [15:0] wait_count, wait_count_next;
  logic [15:0] wait_inc;

  logic [psup_pkg::NODE_COUNT-1:0] valid_bits;

  logic                s1_valid;
  op_t                 s1_op;
  psup_pkg::status_t   s1_status;
  logic [7:0]          s1_dest;
  logic [7:0]          s1_code;
  logic                s1_in_range;
  logic                s1_vbit;

  op_t                 op_next;
  psup_pkg::status_t   status_next;
  logic                in_range_next;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [7:0]    fwd_data;

  logic [7:0]    ram_rdata;
  logic          ram_we;
  logic [7:0]    ram_wdata;

  logic          accept;
  logic          advance;
  logic [7:0]    miss_cur;
  logic [7:0]    miss_after;
  psup_pkg::status_t s1_final;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= psup_pkg::TIMEOUT_RESET;
      retry_limit   <= psup_pkg::RETRY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        psup_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg.data;
        psup_pkg::CFG_RETRY_LIMIT:   retry_limit   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;

  assign wait_inc = (wait_count == psup_pkg::WAIT_MAX) ? wait_count : wait_count + 16'd1;

  always_comb begin
    pending_next    = pending;
    last_dest_next  = last_dest;
    last_code_next  = last_code;
    wait_count_next = wait_count;
    op_next         = OP_NONE;
    status_next     = psup_pkg::ST_IDLE_TICK;
    case (req.command)
      psup_pkg::CMD_SEND: begin
        if (pending) begin
          status_next = psup_pkg::ST_BUSY;
        end else begin
          last_dest_next  = req.dest_node;
          last_code_next  = req.request_code;
          pending_next    = 1'b1;
          wait_count_next = '0;
          status_next     = psup_pkg::ST_SENT;
        end
      end
      psup_pkg::CMD_FRAME: begin
        if (req.frame_id[23:16] == last_dest && req.frame_id[7:0] == last_code) begin
          pending_next = 1'b0;
          op_next      = OP_CLEAR;
          status_next  = psup_pkg::ST_MATCHED;
        end else begin
          status_next = psup_pkg::ST_UNMATCHED;
        end
      end
      psup_pkg::CMD_TICK: begin
        if (pending) begin
          wait_count_next = wait_inc;
          if (wait_inc >= timeout_ticks) begin
            pending_next = 1'b0;
            op_next      = OP_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    in_range_next = {1'b0, last_dest_next} < 9'(psup_pkg::NODE_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      last_dest  <= '0;
      last_code  <= '0;
      wait_count <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        pending    <= pending_next;
        last_dest  <= last_dest_next;
        last_code  <= last_code_next;
        wait_count <= wait_count_next;
        s1_valid   <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= op_next;
      s1_status   <= status_next;
      s1_dest     <= last_dest_next;
      s1_code     <= last_code_next;
      s1_in_range <= in_range_next;
      s1_vbit     <= valid_bits[last_dest_next[AW-1:0]];
    end
  end

  psup_ram #(
    .WIDTH (8),
    .DEPTH (psup_pkg::NODE_COUNT)
  ) u_miss_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_dest[AW-1:0]),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (last_dest_next[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (!s1_in_range) begin
      miss_cur = psup_pkg::MISS_MAX;
    end else if (fwd_valid && fwd_addr == s1_dest[AW-1:0]) begin
      miss_cur = fwd_data;
    end else if (s1_vbit) begin
      miss_cur = ram_rdata;
    end else begin
      miss_cur = psup_pkg::MISS_MAX;
    end

    ram_we     = 1'b0;
    ram_wdata  = '0;
    miss_after = miss_cur;
    s1_final   = s1_status;
    case (s1_op)
      OP_CLEAR: begin
        ram_we     = s1_in_range;
        ram_wdata  = '0;
        miss_after = s1_in_range ? 8'd0 : miss_cur;
      end
      OP_TIMEOUT: begin
        if (miss_cur <= retry_limit) begin
          s1_final = psup_pkg::ST_RETRY;
          if (miss_cur != psup_pkg::MISS_MAX) begin
            ram_we     = s1_in_range;
            ram_wdata  = miss_cur + 8'd1;
            miss_after = miss_cur + 8'd1;
          end
        end else begin
          s1_final = psup_pkg::ST_GIVE_UP;
        end
      end
      default: ;
    endcase
    ram_we = ram_we && advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      fwd_valid  <= 1'b0;
    end else if (ram_we) begin
      valid_bits[s1_dest[AW-1:0]] <= 1'b1;
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= s1_dest[AW-1:0];
      fwd_data <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status         <= s1_final;
      rsp.miss_count_out <= miss_after;
      if (s1_op == OP_TIMEOUT) begin
        rsp.resend_dest <= s1_dest;
        rsp.resend_code <= s1_code;
      end else begin
        rsp.resend_dest <= '0;
        rsp.resend_code <= '0;
      end
    end
  end

endmodule

>>> src/psup_ram.sv
module psup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                  wdata,
  input  logic                              re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
